@@ hdl/svf_mix_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// State-variable filter mixer package
// Widths, register indexes and reset values shared by the filter design.
// ----------------------------------------------------------------------------
package svf_mix_pkg;

   localparam int SAMPLE_WIDTH = 24;
   localparam int STATE_WIDTH  = 32;
   localparam int COEF_WIDTH   = 16;

   // Resonance is Q2.(COEF_WIDTH-2), cutoff is Q0.COEF_WIDTH.
   localparam int RES_SHIFT = COEF_WIDTH - 2;
   localparam int CUT_SHIFT = COEF_WIDTH;

   // Signed state times zero-extended unsigned coefficient.
   localparam int PROD_WIDTH = STATE_WIDTH + COEF_WIDTH + 1;
   // Room for the widest intermediate sum before saturation.
   localparam int SUM_WIDTH  = STATE_WIDTH + 3;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = COEF_WIDTH;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_CUTOFF    = 3'd0,
      CSR_RESONANCE = 3'd1,
      CSR_HP_ENABLE = 3'd2,
      CSR_BP_ENABLE = 3'd3,
      CSR_LP_ENABLE = 3'd4
   } csr_index_type;

   localparam logic [COEF_WIDTH-1:0] CUTOFF_RESET    = COEF_WIDTH'(0);
   localparam logic [COEF_WIDTH-1:0] RESONANCE_RESET = COEF_WIDTH'(1 << RES_SHIFT);

endpackage

@@ hdl/state_variable_filter_mix.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// State-variable filter with response mixing
// One step of a two-integrator filter per sample, with a saturated mix.
// ----------------------------------------------------------------------------
// Each accepted sample runs through a state sequence before its result is offered:
// a single 32 by 17 bit multiplier is shared by the three dependent products
// (band times resonance, high times cutoff, new band times cutoff), and each
// product is registered before the add and saturate step that follows it.
// A new sample is accepted once the previous one has been placed in the
// result register, even while its result beat still waits on rsp_ready.
// Configuration writes must only occur while the filter is idle.
module state_variable_filter_mix (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic signed [svf_mix_pkg::SAMPLE_WIDTH-1:0] req_sample_in,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [svf_mix_pkg::SAMPLE_WIDTH-1:0] rsp_mixed_out,
   output logic signed [svf_mix_pkg::SAMPLE_WIDTH-1:0] rsp_high_out,
   input  logic                                      csr_write_enable,
   input  logic [svf_mix_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [svf_mix_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);

   localparam int SW = svf_mix_pkg::SAMPLE_WIDTH;
   localparam int TW = svf_mix_pkg::STATE_WIDTH;
   localparam int CW = svf_mix_pkg::COEF_WIDTH;
   localparam int PW = svf_mix_pkg::PROD_WIDTH;
   localparam int UW = svf_mix_pkg::SUM_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_RES,
      ST_HIGH,
      ST_MUL_HIGH,
      ST_BAND,
      ST_MUL_BAND,
      ST_LOW,
      ST_MIX
   } state_type;

   function automatic logic signed [TW-1:0] sat_state(input logic signed [UW-1:0] v);
      logic signed [TW-1:0] r;
      if (v[UW-1:TW-1] == {(UW-TW+1){1'b0}} || v[UW-1:TW-1] == {(UW-TW+1){1'b1}}) begin
         r = v[TW-1:0];
      end else if (v[UW-1]) begin
         r = {1'b1, {(TW-1){1'b0}}};
      end else begin
         r = {1'b0, {(TW-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic logic signed [SW-1:0] sat_sample(input logic signed [UW-1:0] v);
      logic signed [SW-1:0] r;
      if (v[UW-1:SW-1] == {(UW-SW+1){1'b0}} || v[UW-1:SW-1] == {(UW-SW+1){1'b1}}) begin
         r = v[SW-1:0];
      end else if (v[UW-1]) begin
         r = {1'b1, {(SW-1){1'b0}}};
      end else begin
         r = {1'b0, {(SW-1){1'b1}}};
      end
      return r;
   endfunction

   logic [CW-1:0]          cutoff_ff;
   logic [CW-1:0]          resonance_ff;
   logic                   hp_enable_ff;
   logic                   bp_enable_ff;
   logic                   lp_enable_ff;

   state_type              state_ff;
   logic signed [SW-1:0]   sample_ff;
   logic signed [TW-1:0]   band_ff;
   logic signed [TW-1:0]   low_ff;
   logic signed [TW-1:0]   high_ff;
   logic signed [PW-1:0]   prod_ff;
   logic                   rsp_valid_ff;
   logic signed [SW-1:0]   mixed_ff;
   logic signed [SW-1:0]   high_out_ff;

   logic signed [TW-1:0]   mul_a;
   logic [CW-1:0]          mul_c;
   logic signed [PW-1:0]   prod_in;
   logic signed [UW-1:0]   high_sum;
   logic signed [UW-1:0]   band_sum;
   logic signed [UW-1:0]   low_sum;
   logic signed [UW-1:0]   mix_sum;
   logic                   out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff    <= svf_mix_pkg::CUTOFF_RESET;
         resonance_ff <= svf_mix_pkg::RESONANCE_RESET;
         hp_enable_ff <= 1'b0;
         bp_enable_ff <= 1'b0;
         lp_enable_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            svf_mix_pkg::CSR_CUTOFF:    cutoff_ff    <= csr_write_data[CW-1:0];
            svf_mix_pkg::CSR_RESONANCE: resonance_ff <= csr_write_data[CW-1:0];
            svf_mix_pkg::CSR_HP_ENABLE: hp_enable_ff <= csr_write_data[0];
            svf_mix_pkg::CSR_BP_ENABLE: bp_enable_ff <= csr_write_data[0];
            svf_mix_pkg::CSR_LP_ENABLE: lp_enable_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (state_ff)
         ST_MUL_RES: begin
            mul_a = band_ff;
            mul_c = resonance_ff;
         end
         ST_MUL_HIGH: begin
            mul_a = high_ff;
            mul_c = cutoff_ff;
         end
         default: begin
            mul_a = band_ff;
            mul_c = cutoff_ff;
         end
      endcase
   end

   assign prod_in  = PW'(mul_a) * $signed({1'b0, mul_c});

   assign high_sum = UW'(sample_ff) + UW'(prod_ff >>> svf_mix_pkg::RES_SHIFT) + UW'(low_ff);
   assign band_sum = UW'(band_ff) - UW'(prod_ff >>> svf_mix_pkg::CUT_SHIFT);
   assign low_sum  = UW'(low_ff) + UW'(prod_ff >>> svf_mix_pkg::CUT_SHIFT);
   assign mix_sum  = (lp_enable_ff ? UW'(low_ff) : UW'(0))
                   - (hp_enable_ff ? UW'(high_ff) : UW'(0))
                   - (bp_enable_ff ? UW'(band_ff) : UW'(0));

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         band_ff      <= '0;
         low_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != ST_MIX) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  sample_ff <= req_sample_in;
                  state_ff  <= ST_MUL_RES;
               end
            end
            ST_MUL_RES: begin
               prod_ff  <= prod_in;
               state_ff <= ST_HIGH;
            end
            ST_HIGH: begin
               high_ff  <= sat_state(high_sum);
               state_ff <= ST_MUL_HIGH;
            end
            ST_MUL_HIGH: begin
               prod_ff  <= prod_in;
               state_ff <= ST_BAND;
            end
            ST_BAND: begin
               band_ff  <= sat_state(band_sum);
               state_ff <= ST_MUL_BAND;
            end
            ST_MUL_BAND: begin
               prod_ff  <= prod_in;
               state_ff <= ST_LOW;
            end
            ST_LOW: begin
               low_ff   <= sat_state(low_sum);
               state_ff <= ST_MIX;
            end
            ST_MIX: begin
               if (out_free) begin
                  mixed_ff     <= sat_sample(mix_sum);
                  high_out_ff  <= sat_sample(UW'(high_ff));
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_mixed_out = mixed_ff;
   assign rsp_high_out  = high_out_ff;

endmodule

@@ test/tb_state_variable_filter_mix.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the state-variable filter with response mixing
// Streams signed samples through the filter under a series of cutoff,
// resonance and mix settings and compares every result beat with a
// cycle-free model of the filter step, including all saturation paths.
// ----------------------------------------------------------------------------
module tb_state_variable_filter_mix;

   localparam int CYCLE_LIMIT      = 400000;
   localparam int SETTLE_CYCLES    = 20;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RANDOM_PHASES    = 12;
   localparam int PHASE_SAMPLES    = 128;

   localparam logic signed [svf_mix_pkg::SAMPLE_WIDTH-1:0] SAMPLE_MAX =
      {1'b0, {(svf_mix_pkg::SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [svf_mix_pkg::SAMPLE_WIDTH-1:0] SAMPLE_MIN =
      {1'b1, {(svf_mix_pkg::SAMPLE_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic signed [svf_mix_pkg::SAMPLE_WIDTH-1:0] mixed;
      logic signed [svf_mix_pkg::SAMPLE_WIDTH-1:0] high;
   } filter_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                          req_valid = 1'b0;
   logic                                          req_ready;
   logic signed [svf_mix_pkg::SAMPLE_WIDTH-1:0]   req_sample_in = '0;
   logic                                          rsp_valid;
   logic                                          rsp_ready = 1'b0;
   logic signed [svf_mix_pkg::SAMPLE_WIDTH-1:0]   rsp_mixed_out;
   logic signed [svf_mix_pkg::SAMPLE_WIDTH-1:0]   rsp_high_out;
   logic                                          csr_write_enable = 1'b0;
   logic [svf_mix_pkg::CSR_INDEX_WIDTH-1:0]       csr_index = svf_mix_pkg::CSR_CUTOFF;
   logic [svf_mix_pkg::CSR_DATA_WIDTH-1:0]        csr_write_data = '0;

   logic [svf_mix_pkg::COEF_WIDTH-1:0] cutoff_setting    = svf_mix_pkg::CUTOFF_RESET;
   logic [svf_mix_pkg::COEF_WIDTH-1:0] resonance_setting = svf_mix_pkg::RESONANCE_RESET;
   logic                               highpass_on       = 1'b0;
   logic                               bandpass_on       = 1'b0;
   logic                               lowpass_on        = 1'b0;
   longint                             band_level        = 0;
   longint                             low_level         = 0;

   logic signed [svf_mix_pkg::SAMPLE_WIDTH-1:0] pending_samples[$];
   filter_result_type                           expected_outputs[$];

   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   logic hold_start      = 1'b0;
   int hold_left         = 0;

   int items_queued     = 0;
   int beats_checked    = 0;
   int clipped_highs    = 0;
   int settings_applied = 0;
   int error_count      = 0;
   int cycle_count      = 0;

   state_variable_filter_mix uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_in    (req_sample_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mixed_out    (rsp_mixed_out),
      .rsp_high_out     (rsp_high_out),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint saturate_to(longint value, int width);
      longint top;
      longint bottom;
      top = (longint'(1) <<< (width - 1)) - 1;
      bottom = -top - 1;
      if (value > top) return top;
      if (value < bottom) return bottom;
      return value;
   endfunction

   function automatic filter_result_type filter_step(
         logic signed [svf_mix_pkg::SAMPLE_WIDTH-1:0] sample);
      filter_result_type result;
      longint high_value;
      longint mix_value;
      high_value = longint'(sample)
                 + ((band_level * longint'(resonance_setting)) >>> svf_mix_pkg::RES_SHIFT)
                 + low_level;
      high_value = saturate_to(high_value, svf_mix_pkg::STATE_WIDTH);
      band_level = saturate_to(band_level
                      - ((high_value * longint'(cutoff_setting)) >>> svf_mix_pkg::CUT_SHIFT),
                               svf_mix_pkg::STATE_WIDTH);
      low_level = saturate_to(low_level
                     + ((band_level * longint'(cutoff_setting)) >>> svf_mix_pkg::CUT_SHIFT),
                              svf_mix_pkg::STATE_WIDTH);
      mix_value = 0;
      if (highpass_on) mix_value -= high_value;
      if (bandpass_on) mix_value -= band_level;
      if (lowpass_on) mix_value += low_level;
      result.mixed = svf_mix_pkg::SAMPLE_WIDTH'(saturate_to(mix_value,
                                                            svf_mix_pkg::SAMPLE_WIDTH));
      result.high = svf_mix_pkg::SAMPLE_WIDTH'(saturate_to(high_value,
                                                           svf_mix_pkg::SAMPLE_WIDTH));
      return result;
   endfunction

   task automatic write_register(logic [svf_mix_pkg::CSR_INDEX_WIDTH-1:0] index,
                                 logic [svf_mix_pkg::CSR_DATA_WIDTH-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      case (index)
         svf_mix_pkg::CSR_CUTOFF:    cutoff_setting = data[svf_mix_pkg::COEF_WIDTH-1:0];
         svf_mix_pkg::CSR_RESONANCE: resonance_setting = data[svf_mix_pkg::COEF_WIDTH-1:0];
         svf_mix_pkg::CSR_HP_ENABLE: highpass_on = data[0];
         svf_mix_pkg::CSR_BP_ENABLE: bandpass_on = data[0];
         svf_mix_pkg::CSR_LP_ENABLE: lowpass_on = data[0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic queue_sample(logic signed [svf_mix_pkg::SAMPLE_WIDTH-1:0] sample);
      pending_samples.push_back(sample);
      items_queued++;
   endtask

   task automatic wait_until_drained;
      while (beats_checked < items_queued) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) expected_outputs.push_back(filter_step(req_sample_in));
         if (!req_valid || req_ready) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_sample_in <= pending_samples.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_start) begin
         hold_left <= LONG_HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin : result_monitor
      filter_result_type wanted;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            beats_checked++;
            if (rsp_high_out == SAMPLE_MAX || rsp_high_out == SAMPLE_MIN) clipped_highs++;
            if (expected_outputs.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result beat, mixed %0d high %0d",
                        $time, rsp_mixed_out, rsp_high_out);
            end else begin
               wanted = expected_outputs.pop_front();
               if (rsp_mixed_out !== wanted.mixed) begin
                  error_count++;
                  $display("%0t: mixed_out expected %0d actual %0d",
                           $time, wanted.mixed, rsp_mixed_out);
               end
               if (rsp_high_out !== wanted.high) begin
                  error_count++;
                  $display("%0t: high_out expected %0d actual %0d",
                           $time, wanted.high, rsp_high_out);
               end
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d of %0d beats received.",
                  cycle_count, beats_checked, items_queued);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      int sel;
      logic signed [svf_mix_pkg::SAMPLE_WIDTH-1:0] sample;
      logic [svf_mix_pkg::CSR_DATA_WIDTH-1:0] cut_data;
      logic [svf_mix_pkg::CSR_DATA_WIDTH-1:0] res_data;
      logic [svf_mix_pkg::CSR_DATA_WIDTH-1:0] hp_data;
      logic [svf_mix_pkg::CSR_DATA_WIDTH-1:0] bp_data;
      logic [svf_mix_pkg::CSR_DATA_WIDTH-1:0] lp_data;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      sender_idle_pct <= 10;
      receiver_idle_pct <= 50;

      // With the reset settings no response is mixed in, so the mix must stay zero.
      queue_sample(SAMPLE_MAX);
      queue_sample(SAMPLE_MIN);
      queue_sample('0);
      wait_until_drained();

      // Enables are written with all bits set so that only bit zero may count.
      write_register(svf_mix_pkg::CSR_CUTOFF, 16'h8000);
      write_register(svf_mix_pkg::CSR_RESONANCE, 16'hFFFF);
      write_register(svf_mix_pkg::CSR_HP_ENABLE, 16'hFFFF);
      write_register(svf_mix_pkg::CSR_BP_ENABLE, 16'hFFFF);
      write_register(svf_mix_pkg::CSR_LP_ENABLE, 16'hFFFF);
      for (int idx = svf_mix_pkg::CSR_LP_ENABLE + 1;
           idx < 2 ** svf_mix_pkg::CSR_INDEX_WIDTH; idx++) begin
         write_register(svf_mix_pkg::CSR_INDEX_WIDTH'(idx), '0);
      end
      settings_applied++;
      repeat (6) queue_sample(SAMPLE_MAX);
      repeat (6) queue_sample(SAMPLE_MIN);
      queue_sample(svf_mix_pkg::SAMPLE_WIDTH'(1));
      queue_sample(svf_mix_pkg::SAMPLE_WIDTH'(-1));
      queue_sample('0);
      queue_sample('0);
      wait_until_drained();

      write_register(svf_mix_pkg::CSR_HP_ENABLE, 16'hFFFE);
      settings_applied++;
      queue_sample(SAMPLE_MAX);
      queue_sample(SAMPLE_MIN);
      queue_sample(svf_mix_pkg::SAMPLE_WIDTH'(1));
      wait_until_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         cut_data = svf_mix_pkg::CSR_DATA_WIDTH'($urandom_range(52428));
         res_data = svf_mix_pkg::CSR_DATA_WIDTH'($urandom());
         hp_data = svf_mix_pkg::CSR_DATA_WIDTH'($urandom());
         bp_data = svf_mix_pkg::CSR_DATA_WIDTH'($urandom());
         lp_data = svf_mix_pkg::CSR_DATA_WIDTH'($urandom());
         case (phase)
            0: begin
               cut_data = '0;
               res_data = '0;
               hp_data = 16'h0001;
               bp_data = 16'h0001;
               lp_data = 16'h0001;
            end
            1: begin
               cut_data = 16'hFFFF;
               res_data = 16'hFFFF;
               hp_data = 16'h0001;
               bp_data = 16'h0001;
               lp_data = 16'h0001;
            end
            2: begin
               cut_data = 16'd1500;
               res_data = svf_mix_pkg::RESONANCE_RESET;
               hp_data = '0;
               bp_data = '0;
               lp_data = 16'h0001;
            end
            3: begin
               cut_data = 16'hFFFF;
               res_data = '0;
               hp_data = '0;
               bp_data = 16'h0001;
               lp_data = '0;
            end
            default: ;
         endcase
         write_register(svf_mix_pkg::CSR_CUTOFF, cut_data);
         write_register(svf_mix_pkg::CSR_RESONANCE, res_data);
         write_register(svf_mix_pkg::CSR_HP_ENABLE, hp_data);
         write_register(svf_mix_pkg::CSR_BP_ENABLE, bp_data);
         write_register(svf_mix_pkg::CSR_LP_ENABLE, lp_data);
         settings_applied++;

         if (phase < RANDOM_PHASES / 3) begin
            sender_idle_pct <= 10;
            receiver_idle_pct <= 50;
         end else if (phase < 2 * RANDOM_PHASES / 3) begin
            sender_idle_pct <= 50;
            receiver_idle_pct <= 10;
         end else begin
            sender_idle_pct <= 0;
            receiver_idle_pct <= 0;
         end

         for (int n = 0; n < PHASE_SAMPLES; n++) begin
            sel = $urandom_range(9);
            case (sel)
               0: sample = SAMPLE_MAX;
               1: sample = SAMPLE_MIN;
               2, 3, 4: sample = svf_mix_pkg::SAMPLE_WIDTH'(int'($urandom_range(8191)) - 4096);
               default: sample = svf_mix_pkg::SAMPLE_WIDTH'($urandom());
            endcase
            queue_sample(sample);
         end

         if (phase == RANDOM_PHASES - 3) begin
            @(posedge clock);
            hold_start <= 1'b1;
            @(posedge clock);
            hold_start <= 1'b0;
         end
         wait_until_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Streamed %0d samples through %0d filter settings, with a long output hold-off.",
               items_queued, settings_applied);
      $display("Checked %0d result beats; %0d of them carried a clipped high-pass value.",
               beats_checked, clipped_highs);
      if (error_count == 0 && expected_outputs.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d results still outstanding.",
                  error_count, expected_outputs.size());
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
